### rtl/core/divisor_sum_prefix_table_macros.svh
// Assertion macros shared by the divisor sum prefix table RTL
`ifndef DIVISOR_SUM_PREFIX_TABLE_MACROS_SVH
`define DIVISOR_SUM_PREFIX_TABLE_MACROS_SVH

// Same-cycle implication, checked out of reset
`define DSPT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dspt: same-cycle check failed");

// Next-cycle implication, checked out of reset
`define DSPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dspt: next-cycle check failed");

`endif

### rtl/core/dspt_pkg.sv
// Types and constants of the divisor sum prefix table
package dspt_pkg;

    localparam int QUERY_W    = 16;
    localparam int TOTAL_W    = 32;
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PW    = 2;
    localparam int OUTQ_CW    = 3;

    typedef enum logic [2:0] {
        BLD_INIT,
        BLD_SIEVE,
        BLD_PREFIX,
        BLD_DRAIN,
        BLD_DONE
    } bld_state_t;

endpackage

### rtl/core/dspt_mem.sv
// Table memory: one write port, one registered read port
module dspt_mem #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [AW-1:0]               waddr,
    input  logic [dspt_pkg::TOTAL_W-1:0] wdata,
    input  logic [AW-1:0]               raddr,
    output logic [dspt_pkg::TOTAL_W-1:0] rdata
);
    import dspt_pkg::*;

    logic [TOTAL_W-1:0] mem [0:DEPTH-1];
    logic [TOTAL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/dspt_build.sv
// Table build sequencer: init sweep, divisor sieve, prefix sum (read-modify-write)
module dspt_build #(
    parameter int MAX_QUERY = 65535,
    parameter int AW        = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [dspt_pkg::TOTAL_W-1:0] mem_rdata,
    output logic                         mem_we,
    output logic [AW-1:0]                mem_waddr,
    output logic [dspt_pkg::TOTAL_W-1:0] mem_wdata,
    output logic [AW-1:0]                mem_raddr,
    output logic                         done
);
    import dspt_pkg::*;

    localparam int         CW       = AW + 1;
    localparam logic [CW-1:0] MAX_C = CW'(MAX_QUERY);
    localparam bit         SIEVE_ON = (MAX_QUERY >= 4);

    bld_state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] d_reg, d_next;

    logic          iss_valid;
    logic [AW-1:0] iss_addr;
    logic [AW-1:0] iss_add;

    logic          p_valid_reg;
    bld_state_t    p_mode_reg;
    logic [AW-1:0] p_addr_reg;
    logic [AW-1:0] p_add_reg;

    logic               lw_valid_reg;
    logic [AW-1:0]      lw_addr_reg;
    logic [TOTAL_W-1:0] lw_data_reg;
    logic [TOTAL_W-1:0] run_reg;

    logic [TOTAL_W-1:0] fwd_data;
    logic [TOTAL_W:0]   run_sum;
    logic [TOTAL_W-1:0] wdata;
    logic [CW-1:0]      step_sum;
    logic [CW-1:0]      d_inc;
    logic [CW-1:0]      d_two;

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        d_next     = d_reg;
        step_sum   = cnt_reg + d_reg;
        d_inc      = d_reg + CW'(1);
        d_two      = {d_inc[CW-2:0], 1'b0};
        case (state_reg)
            BLD_INIT:
            begin
                if (cnt_reg == MAX_C)
                begin
                    if (SIEVE_ON)
                    begin
                        state_next = BLD_SIEVE;
                        cnt_next   = CW'(4);
                        d_next     = CW'(2);
                    end
                    else
                    begin
                        state_next = BLD_PREFIX;
                        cnt_next   = CW'(1);
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            BLD_SIEVE:
            begin
                if (step_sum > MAX_C)
                begin
                    // advance to the next divisor, starting at its double
                    if (d_two > MAX_C)
                    begin
                        state_next = BLD_PREFIX;
                        cnt_next   = CW'(1);
                    end
                    else
                    begin
                        cnt_next = d_two;
                        d_next   = d_inc;
                    end
                end
                else
                begin
                    cnt_next = step_sum;
                end
            end
            BLD_PREFIX:
            begin
                if (cnt_reg == MAX_C)
                begin
                    state_next = BLD_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            BLD_DRAIN:
            begin
                state_next = BLD_DONE;
            end
            BLD_DONE:
            begin
                state_next = BLD_DONE;
            end
            default:
            begin
                state_next = BLD_INIT;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        iss_valid = 1'b0;
        done      = 1'b0;
        iss_addr  = cnt_reg[AW-1:0];
        iss_add   = d_reg[AW-1:0];
        case (state_reg)
            BLD_INIT,
            BLD_SIEVE,
            BLD_PREFIX:
            begin
                iss_valid = 1'b1;
            end
            BLD_DONE:
            begin
                done = 1'b1;
            end
            default:
            begin
                iss_valid = 1'b0;
            end
        endcase
    end

    assign mem_raddr = iss_addr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= BLD_INIT;
            cnt_reg      <= '0;
            d_reg        <= CW'(2);
            p_valid_reg  <= 1'b0;
            p_mode_reg   <= BLD_INIT;
            lw_valid_reg <= 1'b0;
            run_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            d_reg        <= d_next;
            p_valid_reg  <= iss_valid;
            p_mode_reg   <= state_reg;
            lw_valid_reg <= mem_we;
            if (p_valid_reg && p_mode_reg == BLD_PREFIX)
            begin
                run_reg <= wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        p_addr_reg  <= iss_addr;
        p_add_reg   <= iss_add;
        lw_addr_reg <= mem_waddr;
        lw_data_reg <= mem_wdata;
    end

    // bypass the write that landed in the same cycle as our read
    assign fwd_data = (lw_valid_reg && lw_addr_reg == p_addr_reg) ? lw_data_reg : mem_rdata;
    assign run_sum  = {1'b0, run_reg} + {1'b0, fwd_data};

    always_comb
    begin
        case (p_mode_reg)
            BLD_INIT:
            begin
                // seed each entry with 1 + k (entry 1 gets 1, entry 0 gets 0)
                if (p_addr_reg == AW'(0))
                begin
                    wdata = '0;
                end
                else if (p_addr_reg == AW'(1))
                begin
                    wdata = TOTAL_W'(1);
                end
                else
                begin
                    wdata = TOTAL_W'(p_addr_reg) + TOTAL_W'(1);
                end
            end
            BLD_SIEVE:
            begin
                wdata = fwd_data + TOTAL_W'(p_add_reg);
            end
            BLD_PREFIX:
            begin
                wdata = run_sum[TOTAL_W] ? '1 : run_sum[TOTAL_W-1:0];
            end
            default:
            begin
                wdata = fwd_data;
            end
        endcase
    end

    assign mem_we    = p_valid_reg;
    assign mem_waddr = p_addr_reg;
    assign mem_wdata = wdata;

endmodule

### rtl/core/dspt_outq.sv
// Output queue: small FIFO that decouples table reads from the result stream
module dspt_outq (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  logic [dspt_pkg::TOTAL_W-1:0] push_data,
    output logic [dspt_pkg::OUTQ_CW-1:0] count,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [dspt_pkg::TOTAL_W-1:0] m_tdata
);
    import dspt_pkg::*;

    logic [TOTAL_W-1:0] q_data [0:OUTQ_DEPTH-1];
    logic [OUTQ_PW-1:0] wr_ptr_reg;
    logic [OUTQ_PW-1:0] rd_ptr_reg;
    logic [OUTQ_CW-1:0] count_reg;
    logic               pop;

    assign m_tvalid = (count_reg != '0);
    assign pop      = m_tvalid && m_tready;
    assign m_tdata  = q_data[rd_ptr_reg];
    assign count    = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + OUTQ_PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + OUTQ_PW'(1);
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + OUTQ_CW'(1);
                2'b01:   count_reg <= count_reg - OUTQ_CW'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_data[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/core/divisor_sum_prefix_table.sv
// Top level of the divisor sum prefix table
//
// Answers G(n) = sigma(1) + ... + sigma(n), the running sum of divisor sums.
// Slave stream: s_tdata carries query_n. Master stream: m_tdata carries
// divisor_sum_total. Queries above MAX_QUERY return zero.
// After reset the block builds its table in one memory and holds s_tready low:
//   seed sweep        over entries 0..MAX_QUERY
//   divisor sieve     adds d to entries 2d, 3d, ... up to MAX_QUERY, for d = 2..MAX_QUERY/2
//   prefix sum        over entries 1..MAX_QUERY, then a drain state for the last write
// Each build step is one read-modify-write of the memory, one per cycle.
// Once built, one query beat is taken per cycle while s_tready is high; an
// accepted beat is read through the registered memory port, then written into
// the output queue, which raises m_tvalid.
// Results wait in a four-entry output queue; s_tready drops only when the queue
// plus the read in flight fill it, so a stalled receiver loses nothing.
`include "divisor_sum_prefix_table_macros.svh"

module divisor_sum_prefix_table #(
    parameter int MAX_QUERY = 65535
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] query_n
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] divisor_sum_total
);
    import dspt_pkg::*;

    localparam int AW = (MAX_QUERY < 2) ? 1 : $clog2(MAX_QUERY + 1);
    localparam int QW = (AW > QUERY_W) ? AW : QUERY_W;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [TOTAL_W-1:0] mem_wdata;
    logic [AW-1:0]      mem_raddr;
    logic [AW-1:0]      bld_raddr;
    logic [TOTAL_W-1:0] mem_rdata;
    logic               bld_done;

    logic [QW-1:0]      q_ext;
    logic               q_oor;
    logic [AW-1:0]      q_addr;
    logic               q_accept;
    logic               q_inflight_reg;
    logic               q_oor_reg;
    logic [OUTQ_CW-1:0] out_count;
    logic [TOTAL_W-1:0] push_data;

    dspt_build #(
        .MAX_QUERY (MAX_QUERY),
        .AW        (AW)
    ) u_build (
        .clk       (clk),
        .rst_n     (rst_n),
        .mem_rdata (mem_rdata),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (bld_raddr),
        .done      (bld_done)
    );

    dspt_mem #(
        .DEPTH (MAX_QUERY + 1),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign q_ext    = QW'(s_tdata);
    assign q_oor    = (q_ext > QW'(MAX_QUERY));
    assign q_addr   = q_oor ? '0 : q_ext[AW-1:0];
    assign s_tready = bld_done &&
                      ((OUTQ_CW'(out_count) + OUTQ_CW'(q_inflight_reg)) < OUTQ_CW'(OUTQ_DEPTH));
    assign q_accept = s_tvalid && s_tready;
    assign mem_raddr = bld_done ? q_addr : bld_raddr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_inflight_reg <= 1'b0;
        end
        else
        begin
            q_inflight_reg <= q_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        q_oor_reg <= q_oor;
    end

    // drop the table value for queries above the limit
    assign push_data = q_oor_reg ? '0 : mem_rdata;

    dspt_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_inflight_reg),
        .push_data (push_data),
        .count     (out_count),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    `DSPT_ASSERT_IMPLY(a_no_query_during_build, clk, rst_n, q_accept, bld_done)
    `DSPT_ASSERT_IMPLY(a_no_write_after_build, clk, rst_n, bld_done, !mem_we)
    `DSPT_ASSERT_IMPLY(a_outq_no_overflow, clk, rst_n, q_inflight_reg && !(m_tvalid && m_tready), out_count < OUTQ_CW'(OUTQ_DEPTH))
    `DSPT_ASSERT_NEXT(a_read_lands_in_queue, clk, rst_n, q_accept, q_inflight_reg)

endmodule

### sim/tb_divisor_sum_prefix_table.sv
// Testbench for the divisor sum prefix table: waits out the build, then checks G(n) query results
`timescale 1ns / 100ps

module tb_divisor_sum_prefix_table;
    import dspt_pkg::*;

    localparam int MAX_QUERY   = 65535;
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int DRAIN_WAIT  = 20;
    localparam int HOLD_LEN    = 80;

    typedef enum int {
        RX_ALWAYS,
        RX_MOSTLY,
        RX_COIN,
        RX_PERIODIC
    } rx_mode_t;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [QUERY_W-1:0]   s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [TOTAL_W-1:0]   m_tdata;

    logic [TOTAL_W-1:0]   sigma_prefix [0:MAX_QUERY];
    logic [TOTAL_W-1:0]   expected_totals [$];

    rx_mode_t rx_mode       = RX_ALWAYS;
    int       hold_requests = 0;
    int       fail_count    = 0;
    int       cycle_count   = 0;
    int       burst_left    = 0;
    bit       gaps_on       = 1'b0;

    divisor_sum_prefix_table #(
        .MAX_QUERY (MAX_QUERY)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [15:0] query_n
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)     // [31:0] divisor_sum_total
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Sieve of divisor sums, then a running sum saturating at 32 bits
    function automatic void build_sigma_prefix();
        longint unsigned run;
        int unsigned     divisor_acc [];
        divisor_acc = new[MAX_QUERY + 1];
        foreach (divisor_acc[k])
            divisor_acc[k] = 0;
        for (int d = 1; d <= MAX_QUERY; d++)
            for (int m = d; m <= MAX_QUERY; m += d)
                divisor_acc[m] += d;
        run = 0;
        sigma_prefix[0] = '0;
        for (int k = 1; k <= MAX_QUERY; k++)
        begin
            run += divisor_acc[k];
            if (run > 64'hFFFF_FFFF)
                run = 64'hFFFF_FFFF;
            sigma_prefix[k] = run[TOTAL_W-1:0];
        end
    endfunction

    function automatic logic [TOTAL_W-1:0] predict_total(input logic [QUERY_W-1:0] n);
        if (n > MAX_QUERY)
            return '0;
        return sigma_prefix[n];
    endfunction

    // Offer one query beat; on acceptance queue its expected total and maybe idle
    task automatic send_query(input logic [QUERY_W-1:0] n);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= n;
        do
            @(posedge clk);
        while (!s_tready);
        expected_totals.push_back(predict_total(n));
        gap = 0;
        if (gaps_on)
        begin
            if (burst_left > 0)
                burst_left--;
            else
            begin
                burst_left = $urandom_range(0, 12);
                gap        = $urandom_range(1, 6);
            end
        end
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Receiver: a long hold-off when asked, otherwise the current stall pattern
    always @(posedge clk)
    begin : rx_stall
        static int hold_left   = 0;
        static int hold_served = 0;
        static int rx_phase    = 0;
        if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left   = HOLD_LEN;
        end
        rx_phase = (rx_phase + 1) % 8;
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            case (rx_mode)
                RX_ALWAYS:   m_tready <= 1'b1;
                RX_MOSTLY:   m_tready <= ($urandom_range(0, 3) != 0);
                RX_COIN:     m_tready <= 1'($urandom_range(0, 1));
                RX_PERIODIC: m_tready <= (rx_phase >= 3);
                default:     m_tready <= 1'b1;
            endcase
        end
    end

    // Compare each result beat with the oldest expected total
    always @(posedge clk)
    begin
        logic [TOTAL_W-1:0] want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_totals.size() == 0)
            begin
                $error("divisor_sum_total: unexpected beat, actual %0d", m_tdata);
                fail_count++;
            end
            else
            begin
                want = expected_totals.pop_front();
                if (m_tdata !== want)
                begin
                    $error("divisor_sum_total: expected %0d, actual %0d", want, m_tdata);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_divisor_sum_prefix_table: FAIL");
            $finish;
        end
    end

    task automatic test_reset_and_build();
        build_sigma_prefix();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        // Hold off until the table build releases the input
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic test_directed_queries();
        logic [QUERY_W-1:0] picks [$];
        picks = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd6, 16'd12, 16'd100,
                  16'd1000, 16'd32767, 16'd32768, 16'd65534, 16'd65535, 16'hAAAA,
                  16'h5555, 16'd0, 16'hFFFF};
        rx_mode = RX_ALWAYS;
        gaps_on = 1'b0;
        foreach (picks[i])
            send_query(picks[i]);
    endtask

    task automatic test_random_queries(input int count);
        logic [QUERY_W-1:0] n;
        for (int i = 0; i < count; i++)
        begin
            // Switch stall pattern and idling every segment
            if (i % 250 == 0)
            begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                gaps_on = ($urandom_range(0, 2) != 0);
            end
            case ($urandom_range(0, 3))
                0:       n = QUERY_W'($urandom_range(0, 64));
                1:       n = QUERY_W'($urandom_range(65000, 65535));
                default: n = QUERY_W'($urandom_range(0, 65535));
            endcase
            send_query(n);
        end
    endtask

    task automatic test_receiver_hold_off(input int count);
        rx_mode = RX_ALWAYS;
        gaps_on = 1'b0;
        hold_requests++;
        for (int i = 0; i < count; i++)
            send_query(QUERY_W'($urandom_range(0, 65535)));
        gaps_on = 1'b1;
    endtask

    initial
    begin
        test_reset_and_build();
        test_directed_queries();
        test_random_queries(800);
        test_receiver_hold_off(120);
        test_random_queries(760);
        s_tvalid <= 1'b0;
        while (expected_totals.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0)
            $display("tb_divisor_sum_prefix_table: PASS");
        else
            $display("tb_divisor_sum_prefix_table: FAIL");
        $finish;
    end

endmodule

### files.f
+incdir+rtl/core
rtl/core/dspt_pkg.sv
rtl/core/dspt_mem.sv
rtl/core/dspt_build.sv
rtl/core/dspt_outq.sv
rtl/core/divisor_sum_prefix_table.sv
sim/tb_divisor_sum_prefix_table.sv
